### sv/swt_pkg.sv
package swt_pkg;

   // Lexer position within the line
   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_ESC     = 3'd2,
      MODE_SQ      = 3'd3,
      MODE_DQ      = 3'd4,
      MODE_DQ_ESC  = 3'd5
   } lex_mode_type;

   // Line status, first error wins
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TOO_LONG    = 3'd1,
      STATUS_OPEN_QUOTE  = 3'd2,
      STATUS_TRAIL_ESC   = 3'd3,
      STATUS_SECOND_PIPE = 3'd4,
      STATUS_TOO_MANY    = 3'd5,
      STATUS_EMPTY_SIDE  = 3'd6
   } status_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PIPE   = 8'h7C;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;

   typedef struct packed {
      logic       has_char;
      logic [7:0] out_char;
      logic [3:0] word_index;
      logic       word_end;
      logic       pipe_here;
      logic       line_end;
      status_type status;
      logic [4:0] arg_count;
      logic       has_pipe;
      logic [4:0] pipe_pos;
   } result_type;

endpackage

### sv/swt_lexer.sv
module swt_lexer #(
   parameter int WORD_MAX = 128,
   parameter int ARGS_MAX = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           ch,
   input  logic                 last,
   output swt_pkg::result_type  result
);

   localparam int LW = (WORD_MAX > 2) ? $clog2(WORD_MAX) : 1;
   localparam int CW = $clog2(ARGS_MAX + 1);

   swt_pkg::lex_mode_type mode_ff, mode_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [CW-1:0]         tot_ff, tot_in;
   logic                  pseen_ff, pseen_in;
   logic [CW-1:0]         pidx_ff, pidx_in;
   swt_pkg::status_type   err_ff, err_in;

   swt_pkg::lex_mode_type m;
   logic [LW-1:0]         len;
   logic [CW-1:0]         tot;
   logic                  pseen;
   logic [CW-1:0]         pidx;
   swt_pkg::status_type   err;
   logic                  wb, app, cls, pip;
   logic                  r_has, r_end, r_pipe;
   logic [7:0]            r_char;
   logic [3:0]            r_idx;

   always_comb begin
      m      = mode_ff;
      len    = len_ff;
      tot    = tot_ff;
      pseen  = pseen_ff;
      pidx   = pidx_ff;
      err    = err_ff;
      wb     = 1'b0;
      app    = 1'b0;
      cls    = 1'b0;
      pip    = 1'b0;
      r_has  = 1'b0;
      r_char = 8'd0;
      r_idx  = 4'd0;
      r_end  = 1'b0;
      r_pipe = 1'b0;

      if (ch != swt_pkg::CHAR_NUL && err == swt_pkg::STATUS_OK) begin
         unique case (m)
            swt_pkg::MODE_BETWEEN: begin
               if (ch == swt_pkg::CHAR_SPACE) begin
                  wb = 1'b0;
               end else if (ch == swt_pkg::CHAR_PIPE) begin
                  pip = 1'b1;
               end else if (32'(tot) >= 32'(ARGS_MAX)) begin
                  err = swt_pkg::STATUS_TOO_MANY;
               end else begin
                  len = '0;
                  m   = swt_pkg::MODE_WORD;
                  wb  = 1'b1;
               end
            end
            swt_pkg::MODE_WORD: wb = 1'b1;
            swt_pkg::MODE_ESC: begin
               m   = swt_pkg::MODE_WORD;
               app = 1'b1;
            end
            swt_pkg::MODE_SQ: begin
               if (ch == swt_pkg::CHAR_SQUOTE) m = swt_pkg::MODE_WORD;
               else app = 1'b1;
            end
            swt_pkg::MODE_DQ: begin
               if (ch == swt_pkg::CHAR_DQUOTE) m = swt_pkg::MODE_WORD;
               else if (ch == swt_pkg::CHAR_BSLASH) m = swt_pkg::MODE_DQ_ESC;
               else app = 1'b1;
            end
            default: begin
               m   = swt_pkg::MODE_DQ;
               app = 1'b1;
            end
         endcase

         if (wb) begin
            priority if (ch == swt_pkg::CHAR_SPACE) begin
               cls = 1'b1;
            end else if (ch == swt_pkg::CHAR_PIPE) begin
               cls = 1'b1;
               pip = 1'b1;
            end else if (ch == swt_pkg::CHAR_BSLASH) begin
               m = swt_pkg::MODE_ESC;
            end else if (ch == swt_pkg::CHAR_SQUOTE) begin
               m = swt_pkg::MODE_SQ;
            end else if (ch == swt_pkg::CHAR_DQUOTE) begin
               m = swt_pkg::MODE_DQ;
            end else begin
               app = 1'b1;
            end
         end

         if (app) begin
            if (32'(len) >= 32'(WORD_MAX - 1)) begin
               err = swt_pkg::STATUS_TOO_LONG;
            end else begin
               len    = len + 1'b1;
               r_has  = 1'b1;
               r_char = ch;
               r_idx  = 4'(tot);
            end
         end

         if (cls) begin
            r_end = 1'b1;
            r_idx = 4'(tot);
            tot   = tot + 1'b1;
            m     = swt_pkg::MODE_BETWEEN;
         end

         if (pip) begin
            if (32'(tot) >= 32'(ARGS_MAX)) begin
               err = swt_pkg::STATUS_TOO_MANY;
            end else if (pseen) begin
               err = swt_pkg::STATUS_SECOND_PIPE;
            end else begin
               pseen  = 1'b1;
               pidx   = tot;
               r_pipe = 1'b1;
            end
         end
      end

      // Close out the line
      if (last && err == swt_pkg::STATUS_OK) begin
         if (m == swt_pkg::MODE_WORD) begin
            r_end = 1'b1;
            r_idx = 4'(tot);
            tot   = tot + 1'b1;
            m     = swt_pkg::MODE_BETWEEN;
         end else if (m == swt_pkg::MODE_ESC) begin
            err = swt_pkg::STATUS_TRAIL_ESC;
         end else if (m != swt_pkg::MODE_BETWEEN) begin
            err = swt_pkg::STATUS_OPEN_QUOTE;
         end
         if (err == swt_pkg::STATUS_OK && pseen && (pidx == '0 || pidx >= tot)) begin
            err = swt_pkg::STATUS_EMPTY_SIDE;
         end
      end

      result.has_char   = r_has;
      result.out_char   = r_char;
      result.word_index = r_idx;
      result.word_end   = r_end;
      result.pipe_here  = r_pipe;
      result.line_end   = last;
      result.status     = last ? err : swt_pkg::STATUS_OK;
      result.arg_count  = last ? 5'(tot) : 5'd0;
      result.has_pipe   = last & pseen;
      result.pipe_pos   = last ? 5'(pidx) : 5'd0;

      // A finished line drops all state back to its reset values
      if (last) begin
         mode_in  = swt_pkg::MODE_BETWEEN;
         len_in   = '0;
         tot_in   = '0;
         pseen_in = 1'b0;
         pidx_in  = '0;
         err_in   = swt_pkg::STATUS_OK;
      end else begin
         mode_in  = m;
         len_in   = len;
         tot_in   = tot;
         pseen_in = pseen;
         pidx_in  = pidx;
         err_in   = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= swt_pkg::MODE_BETWEEN;
         len_ff   <= '0;
         tot_ff   <= '0;
         pseen_ff <= 1'b0;
         pidx_ff  <= '0;
         err_ff   <= swt_pkg::STATUS_OK;
      end else if (step) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         tot_ff   <= tot_in;
         pseen_ff <= pseen_in;
         pidx_ff  <= pidx_in;
         err_ff   <= err_in;
      end
   end

endmodule

### sv/shell_word_tokenizer.sv
// Channel     | Direction | Handshake             | Payload
// ------------+-----------+-----------------------+-------------------------------------------
// request     | in        | req_valid / req_ready | req_ch, req_last
// response    | out       | rsp_valid / rsp_ready | rsp_has_char .. rsp_pipe_pos (10 fields)
//
// One transaction in, one transaction out; one byte per cycle unless the response stalls.
// A byte passes the request register, then the lexer step into the response register.
// The lexer state advances once per byte, as the byte moves into the response register.
// Reset is synchronous and active high; it empties both registers and clears the line state.
// A stalled response holds both stages; the request side keeps taking while a slot is free.
module shell_word_tokenizer #(
   parameter int WORD_MAX = 128,
   parameter int ARGS_MAX = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_has_char,
   output logic [7:0] rsp_out_char,
   output logic [3:0] rsp_word_index,
   output logic       rsp_word_end,
   output logic       rsp_pipe_here,
   output logic       rsp_line_end,
   output logic [2:0] rsp_status,
   output logic [4:0] rsp_arg_count,
   output logic       rsp_has_pipe,
   output logic [4:0] rsp_pipe_pos
);

   logic                in_valid_ff;
   logic [7:0]          ch_ff;
   logic                last_ff;
   logic                rsp_valid_ff;
   swt_pkg::result_type res_ff;
   swt_pkg::result_type res_in;
   logic                advance;

   // Move the held byte into the response register when that slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   swt_lexer #(
      .WORD_MAX (WORD_MAX),
      .ARGS_MAX (ARGS_MAX)
   ) u_lexer (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .ch     (ch_ff),
      .last   (last_ff),
      .result (res_in)
   );

   // Control: stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ch_ff   <= req_ch;
         last_ff <= req_last;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_char   = res_ff.has_char;
   assign rsp_out_char   = res_ff.out_char;
   assign rsp_word_index = res_ff.word_index;
   assign rsp_word_end   = res_ff.word_end;
   assign rsp_pipe_here  = res_ff.pipe_here;
   assign rsp_line_end   = res_ff.line_end;
   assign rsp_status     = res_ff.status;
   assign rsp_arg_count  = res_ff.arg_count;
   assign rsp_has_pipe   = res_ff.has_pipe;
   assign rsp_pipe_pos   = res_ff.pipe_pos;

endmodule

### sv/swt_checker.sv
module swt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_ch,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_has_char,
   input logic [7:0] rsp_out_char,
   input logic [3:0] rsp_word_index,
   input logic       rsp_word_end,
   input logic       rsp_pipe_here,
   input logic       rsp_line_end,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_arg_count,
   input logic       rsp_has_pipe,
   input logic [4:0] rsp_pipe_pos
);

   // Response holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
         $stable(rsp_line_end) && $stable(rsp_status) && $stable(rsp_word_end))
      else $error("response changed while stalled");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Summary fields are zero away from line end
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_end |->
         rsp_status == swt_pkg::STATUS_OK && rsp_arg_count == 5'd0 && !rsp_has_pipe &&
         rsp_pipe_pos == 5'd0)
      else $error("summary fields set before line end");

   // A clean line with a pipe has words on both sides
   a_pipe_sides: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end && rsp_status == swt_pkg::STATUS_OK && rsp_has_pipe |->
         rsp_pipe_pos != 5'd0 && rsp_pipe_pos < rsp_arg_count)
      else $error("clean line with an empty pipe side");

   // No byte means a zero byte field
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_char |-> rsp_out_char == 8'd0)
      else $error("out_char set without has_char");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WORD_MAX   = 128;
   localparam int ARGS_MAX   = 16;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 12;
   localparam int ITEM_GOAL  = 1350;
   localparam int DIR_ROWS   = 25;

   // One byte of a command line, as it goes onto the request channel.
   // Pinned rows carry a result typed in by hand; others are predicted.
   typedef struct {
      logic [7:0]          ch;
      logic                last;
      bit                  pinned;
      swt_pkg::result_type want;
   } line_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_has_char;
   logic [7:0] rsp_out_char;
   logic [3:0] rsp_word_index;
   logic       rsp_word_end;
   logic       rsp_pipe_here;
   logic       rsp_line_end;
   logic [2:0] rsp_status;
   logic [4:0] rsp_arg_count;
   logic       rsp_has_pipe;
   logic [4:0] rsp_pipe_pos;

   shell_word_tokenizer #(
      .WORD_MAX(WORD_MAX),
      .ARGS_MAX(ARGS_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_has_char(rsp_has_char),
      .rsp_out_char(rsp_out_char),
      .rsp_word_index(rsp_word_index),
      .rsp_word_end(rsp_word_end),
      .rsp_pipe_here(rsp_pipe_here),
      .rsp_line_end(rsp_line_end),
      .rsp_status(rsp_status),
      .rsp_arg_count(rsp_arg_count),
      .rsp_has_pipe(rsp_has_pipe),
      .rsp_pipe_pos(rsp_pipe_pos)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: its own copy of the line state
   // ------------------------------------------------------------------
   swt_pkg::lex_mode_type lex_state;
   int unsigned           cur_word_len;
   int unsigned           words_done;
   int unsigned           pipe_word;
   bit                    pipe_taken;
   swt_pkg::status_type   line_status;
   swt_pkg::result_type   token_out;

   function void clear_line();
      lex_state    = swt_pkg::MODE_BETWEEN;
      cur_word_len = 0;
      words_done   = 0;
      pipe_word    = 0;
      pipe_taken   = 1'b0;
      line_status  = swt_pkg::STATUS_OK;
   endfunction

   // Keep only the first error of the line.
   function void flag_error(input swt_pkg::status_type code);
      if (line_status == swt_pkg::STATUS_OK) line_status = code;
   endfunction

   function void add_char(input logic [7:0] c);
      if (cur_word_len >= WORD_MAX - 1) begin
         flag_error(swt_pkg::STATUS_TOO_LONG);
      end else begin
         cur_word_len++;
         token_out.has_char   = 1'b1;
         token_out.out_char   = c;
         token_out.word_index = 4'(words_done);
      end
   endfunction

   function void end_word();
      token_out.word_end   = 1'b1;
      token_out.word_index = 4'(words_done);
      words_done++;
      lex_state = swt_pkg::MODE_BETWEEN;
   endfunction

   function void take_pipe();
      if (words_done >= ARGS_MAX) begin
         flag_error(swt_pkg::STATUS_TOO_MANY);
      end else if (pipe_taken) begin
         flag_error(swt_pkg::STATUS_SECOND_PIPE);
      end else begin
         pipe_taken          = 1'b1;
         pipe_word           = words_done;
         token_out.pipe_here = 1'b1;
      end
   endfunction

   // Byte seen inside an unquoted word.
   function void word_char(input logic [7:0] c);
      if (c == swt_pkg::CHAR_SPACE) begin
         end_word();
      end else if (c == swt_pkg::CHAR_PIPE) begin
         end_word();
         take_pipe();
      end else if (c == swt_pkg::CHAR_BSLASH) begin
         lex_state = swt_pkg::MODE_ESC;
      end else if (c == swt_pkg::CHAR_SQUOTE) begin
         lex_state = swt_pkg::MODE_SQ;
      end else if (c == swt_pkg::CHAR_DQUOTE) begin
         lex_state = swt_pkg::MODE_DQ;
      end else begin
         add_char(c);
      end
   endfunction

   function void lex_char(input logic [7:0] c);
      case (lex_state)
         swt_pkg::MODE_BETWEEN: begin
            if (c == swt_pkg::CHAR_PIPE) begin
               take_pipe();
            end else if (c != swt_pkg::CHAR_SPACE) begin
               if (words_done >= ARGS_MAX) begin
                  flag_error(swt_pkg::STATUS_TOO_MANY);
               end else begin
                  cur_word_len = 0;
                  lex_state    = swt_pkg::MODE_WORD;
                  word_char(c);
               end
            end
         end
         swt_pkg::MODE_WORD: word_char(c);
         swt_pkg::MODE_ESC: begin
            lex_state = swt_pkg::MODE_WORD;
            add_char(c);
         end
         swt_pkg::MODE_SQ: begin
            if (c == swt_pkg::CHAR_SQUOTE) lex_state = swt_pkg::MODE_WORD;
            else add_char(c);
         end
         swt_pkg::MODE_DQ: begin
            if (c == swt_pkg::CHAR_DQUOTE) lex_state = swt_pkg::MODE_WORD;
            else if (c == swt_pkg::CHAR_BSLASH) lex_state = swt_pkg::MODE_DQ_ESC;
            else add_char(c);
         end
         default: begin
            lex_state = swt_pkg::MODE_DQ;
            add_char(c);
         end
      endcase
   endfunction

   function swt_pkg::result_type tokenize_byte(input logic [7:0] c, input logic lst);
      token_out = '0;
      if (c != swt_pkg::CHAR_NUL && line_status == swt_pkg::STATUS_OK) lex_char(c);
      if (lst && line_status == swt_pkg::STATUS_OK) begin
         if (lex_state == swt_pkg::MODE_WORD) end_word();
         else if (lex_state == swt_pkg::MODE_ESC) flag_error(swt_pkg::STATUS_TRAIL_ESC);
         else if (lex_state != swt_pkg::MODE_BETWEEN) flag_error(swt_pkg::STATUS_OPEN_QUOTE);
         if (line_status == swt_pkg::STATUS_OK && pipe_taken &&
             (pipe_word == 0 || pipe_word >= words_done))
            flag_error(swt_pkg::STATUS_EMPTY_SIDE);
      end
      if (lst) begin
         token_out.line_end  = 1'b1;
         token_out.status    = line_status;
         token_out.arg_count = 5'(words_done);
         token_out.has_pipe  = pipe_taken;
         token_out.pipe_pos  = 5'(pipe_word);
         clear_line();
      end
      return token_out;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus: directed table, then generated command lines
   // ------------------------------------------------------------------
   line_byte_type       dir_table [DIR_ROWS];
   line_byte_type       line_bytes [$];
   logic [7:0]          line_buf [$];
   swt_pkg::result_type expected_tokens [$];

   // Hand-written line-end result; word_index is zero on every pinned row.
   function swt_pkg::result_type line_result(input logic has, input logic [7:0] c,
                                             input logic wend, input logic pipe,
                                             input swt_pkg::status_type st,
                                             input logic [4:0] cnt, input logic hp,
                                             input logic [4:0] pos);
      swt_pkg::result_type r;
      r = '0;
      r.has_char  = has;
      r.out_char  = c;
      r.word_end  = wend;
      r.pipe_here = pipe;
      r.line_end  = 1'b1;
      r.status    = st;
      r.arg_count = cnt;
      r.has_pipe  = hp;
      r.pipe_pos  = pos;
      return r;
   endfunction

   function line_byte_type row(input logic [7:0] c, input logic lst);
      line_byte_type b;
      b.ch     = c;
      b.last   = lst;
      b.pinned = 1'b0;
      b.want   = '0;
      return b;
   endfunction

   function line_byte_type pinned_row(input logic [7:0] c, input swt_pkg::result_type w);
      line_byte_type b;
      b        = row(c, 1'b1);
      b.pinned = 1'b1;
      b.want   = w;
      return b;
   endfunction

   function void load_directed();
      // single-byte lines: plain byte, empty line, top byte, lone escape,
      // lone quote, lone pipe (empty side)
      dir_table[0]  = pinned_row(8'h61,
                                 line_result(1'b1, 8'h61, 1'b1, 1'b0, swt_pkg::STATUS_OK,
                                             5'd1, 1'b0, 5'd0));
      dir_table[1]  = pinned_row(swt_pkg::CHAR_NUL,
                                 line_result(1'b0, 8'h00, 1'b0, 1'b0, swt_pkg::STATUS_OK,
                                             5'd0, 1'b0, 5'd0));
      dir_table[2]  = pinned_row(8'hFF,
                                 line_result(1'b1, 8'hFF, 1'b1, 1'b0, swt_pkg::STATUS_OK,
                                             5'd1, 1'b0, 5'd0));
      dir_table[3]  = pinned_row(swt_pkg::CHAR_BSLASH,
                                 line_result(1'b0, 8'h00, 1'b0, 1'b0,
                                             swt_pkg::STATUS_TRAIL_ESC, 5'd0, 1'b0, 5'd0));
      dir_table[4]  = pinned_row(swt_pkg::CHAR_SQUOTE,
                                 line_result(1'b0, 8'h00, 1'b0, 1'b0,
                                             swt_pkg::STATUS_OPEN_QUOTE, 5'd0, 1'b0, 5'd0));
      dir_table[5]  = pinned_row(swt_pkg::CHAR_PIPE,
                                 line_result(1'b0, 8'h00, 1'b0, 1'b1,
                                             swt_pkg::STATUS_EMPTY_SIDE, 5'd0, 1'b1, 5'd0));
      // a\ b|c : escaped space, pipe ending an unquoted word
      dir_table[6]  = row(8'h61, 1'b0);
      dir_table[7]  = row(swt_pkg::CHAR_BSLASH, 1'b0);
      dir_table[8]  = row(swt_pkg::CHAR_SPACE, 1'b0);
      dir_table[9]  = row(8'h62, 1'b0);
      dir_table[10] = row(swt_pkg::CHAR_PIPE, 1'b0);
      dir_table[11] = row(8'h63, 1'b1);
      // "x\"" '' : escape inside double quotes, then an empty word
      dir_table[12] = row(swt_pkg::CHAR_DQUOTE, 1'b0);
      dir_table[13] = row(8'h78, 1'b0);
      dir_table[14] = row(swt_pkg::CHAR_BSLASH, 1'b0);
      dir_table[15] = row(swt_pkg::CHAR_DQUOTE, 1'b0);
      dir_table[16] = row(swt_pkg::CHAR_DQUOTE, 1'b0);
      dir_table[17] = row(swt_pkg::CHAR_SPACE, 1'b0);
      dir_table[18] = row(swt_pkg::CHAR_SQUOTE, 1'b0);
      dir_table[19] = row(swt_pkg::CHAR_SQUOTE, 1'b1);
      // || : second pipe
      dir_table[20] = row(swt_pkg::CHAR_PIPE, 1'b0);
      dir_table[21] = row(swt_pkg::CHAR_PIPE, 1'b1);
      // ignored zero byte, then a line ending after an escape in double quotes
      dir_table[22] = row(swt_pkg::CHAR_NUL, 1'b0);
      dir_table[23] = row(swt_pkg::CHAR_DQUOTE, 1'b0);
      dir_table[24] = row(swt_pkg::CHAR_BSLASH, 1'b1);
   endfunction

   function logic [7:0] pick_plain();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == swt_pkg::CHAR_SPACE || c == swt_pkg::CHAR_PIPE ||
                 c == swt_pkg::CHAR_BSLASH || c == swt_pkg::CHAR_SQUOTE ||
                 c == swt_pkg::CHAR_DQUOTE);
      return c;
   endfunction

   function logic [7:0] pick_special();
      case ($urandom_range(0, 5))
         0: return swt_pkg::CHAR_SPACE;
         1: return swt_pkg::CHAR_PIPE;
         2: return swt_pkg::CHAR_BSLASH;
         3: return swt_pkg::CHAR_SQUOTE;
         4: return swt_pkg::CHAR_DQUOTE;
         default: return swt_pkg::CHAR_NUL;
      endcase
   endfunction

   // Push one word that always ends outside any quote or escape.
   function void put_word();
      int n;
      logic [7:0] c;
      if ($urandom_range(0, 24) == 0) begin
         // long word around the WORD_MAX boundary
         n = $urandom_range(WORD_MAX - 10, WORD_MAX + 6);
         repeat (n) line_buf.push_back(pick_plain());
         return;
      end
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 5))
            3: begin
               line_buf.push_back(swt_pkg::CHAR_BSLASH);
               line_buf.push_back(8'($urandom_range(1, 255)));
            end
            4: begin
               line_buf.push_back(swt_pkg::CHAR_SQUOTE);
               repeat ($urandom_range(0, 4)) begin
                  do c = 8'($urandom_range(1, 255)); while (c == swt_pkg::CHAR_SQUOTE);
                  line_buf.push_back(c);
               end
               line_buf.push_back(swt_pkg::CHAR_SQUOTE);
            end
            5: begin
               line_buf.push_back(swt_pkg::CHAR_DQUOTE);
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     line_buf.push_back(swt_pkg::CHAR_BSLASH);
                     line_buf.push_back(8'($urandom_range(1, 255)));
                  end else begin
                     do c = 8'($urandom_range(1, 255));
                     while (c == swt_pkg::CHAR_DQUOTE || c == swt_pkg::CHAR_BSLASH);
                     line_buf.push_back(c);
                  end
               end
               line_buf.push_back(swt_pkg::CHAR_DQUOTE);
            end
            default: repeat ($urandom_range(1, 4)) line_buf.push_back(pick_plain());
         endcase
         if ($urandom_range(0, 15) == 0) line_buf.push_back(swt_pkg::CHAR_NUL);
      end
   endfunction

   function void put_spaces(input int lo);
      repeat ($urandom_range(lo, 3)) line_buf.push_back(swt_pkg::CHAR_SPACE);
      if ($urandom_range(0, 15) == 0) line_buf.push_back(swt_pkg::CHAR_NUL);
   endfunction

   function void put_pipe();
      if ($urandom_range(0, 1) == 1) line_buf.push_back(swt_pkg::CHAR_SPACE);
      line_buf.push_back(swt_pkg::CHAR_PIPE);
      if ($urandom_range(0, 1) == 1) line_buf.push_back(swt_pkg::CHAR_SPACE);
   endfunction

   // Build one command line and queue it, last set on its final byte.
   function void add_line();
      int kind;
      int nwords;
      int pipe_at;
      int pipe_again;
      int cut;
      line_byte_type b;
      line_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
         // noise: random bytes, heavy on the special characters
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 1) == 1) line_buf.push_back(pick_special());
            else line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         nwords     = ($urandom_range(0, 11) == 0) ? $urandom_range(ARGS_MAX - 2, ARGS_MAX + 2)
                                                   : $urandom_range(0, 5);
         pipe_at    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nwords) : -1;
         pipe_again = ($urandom_range(0, 19) == 0) ? $urandom_range(0, nwords) : -1;
         if ($urandom_range(0, 3) == 0) put_spaces(1);
         for (int w = 0; w < nwords; w++) begin
            if (w == pipe_at) put_pipe();
            if (w == pipe_again) put_pipe();
            put_word();
            if (w < nwords - 1) put_spaces(1);
         end
         if (pipe_at == nwords) put_pipe();
         if (pipe_again == nwords) put_pipe();
         case ($urandom_range(0, 3))
            1: line_buf.push_back(swt_pkg::CHAR_SPACE);
            2: line_buf.push_back(swt_pkg::CHAR_NUL);
            default: ;
         endcase
         // broken line: stop at a random point, often inside a quote
         if (kind >= 70 && line_buf.size() > 1) begin
            cut = $urandom_range(0, line_buf.size() - 2);
            while (line_buf.size() > cut + 1) void'(line_buf.pop_back());
         end
      end
      if (line_buf.size() == 0) line_buf.push_back(swt_pkg::CHAR_NUL);
      foreach (line_buf[i]) begin
         b = row(line_buf[i], i == line_buf.size() - 1);
         line_bytes.push_back(b);
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts with gaps, predictor stepped on each accepted byte
   // ------------------------------------------------------------------
   int send_idx   = 0;
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_req
      bit                  taken;
      swt_pkg::result_type r;
      taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            // step the predictor on the transaction just taken
            r = tokenize_byte(line_bytes[send_idx].ch, line_bytes[send_idx].last);
            if (line_bytes[send_idx].pinned)
               expected_tokens.push_back(line_bytes[send_idx].want);
            else
               expected_tokens.push_back(r);
            send_idx++;
            taken = 1'b1;
         end
         if (!req_valid || taken) begin
            if (gap_left > 0) begin
               // hold off: idle gap between bursts
               gap_left--;
               req_valid <= 1'b0;
            end else if (send_idx < line_bytes.size()) begin
               req_valid <= 1'b1;
               req_ch    <= line_bytes[send_idx].ch;
               req_last  <= line_bytes[send_idx].last;
               if (burst_left <= 1) begin
                  // new burst; now and then a long run with no idling at all
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                           : $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response sink: stall patterns that change every so often
   // ------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_left = 0;
   int duty_phase = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(64, 256);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: begin
               duty_phase++;
               rsp_ready <= (duty_phase % 4) != 0;
            end
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_ready <= 1'b0;
               end else if ($urandom_range(0, 9) == 0) begin
                  stall_left = $urandom_range(3, 20);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Checker: every accepted response against the oldest expectation
   // ------------------------------------------------------------------
   int mismatches = 0;
   int rsp_seen   = 0;

   function void show_token(input string tag, input swt_pkg::result_type t);
      $display({"  %s: has=%0d ch=%02h idx=%0d end=%0d pipe=%0d le=%0d",
                " st=%0d cnt=%0d hp=%0d pos=%0d"},
               tag, t.has_char, t.out_char, t.word_index, t.word_end, t.pipe_here,
               t.line_end, t.status, t.arg_count, t.has_pipe, t.pipe_pos);
   endfunction

   always @(posedge clock) begin : check_rsp
      swt_pkg::result_type seen;
      swt_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.has_char   = rsp_has_char;
         seen.out_char   = rsp_out_char;
         seen.word_index = rsp_word_index;
         seen.word_end   = rsp_word_end;
         seen.pipe_here  = rsp_pipe_here;
         seen.line_end   = rsp_line_end;
         seen.status     = swt_pkg::status_type'(rsp_status);
         seen.arg_count  = rsp_arg_count;
         seen.has_pipe   = rsp_has_pipe;
         seen.pipe_pos   = rsp_pipe_pos;
         if (expected_tokens.size() == 0) begin
            // drop into the error count: nothing was waiting for this one
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d arrived with no byte outstanding", rsp_seen);
               show_token("actual", seen);
            end
         end else begin
            want = expected_tokens.pop_front();
            if (want !== seen) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d mismatch", rsp_seen);
                  show_token("expected", want);
                  show_token("actual", seen);
               end
            end
         end
         rsp_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: build stimulus, reset, drain, report
   // ------------------------------------------------------------------
   initial begin
      clear_line();
      load_directed();
      for (int i = 0; i < DIR_ROWS; i++) line_bytes.push_back(dir_table[i]);
      while (line_bytes.size() < DIR_ROWS + ITEM_GOAL) add_line();

      // hold reset once, at the start of the run
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // advance until every byte is taken and every response is back
      while (!(send_idx == line_bytes.size() && expected_tokens.size() == 0))
         @(posedge clock);
      // let the pipeline settle so a stray extra response would still be seen
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
